// ===== sv/rhc_pkg.sv =====
package rhc_pkg;

  localparam int SECTOR_DEG = 60;
  localparam int TURN_DEG   = 360;
  localparam int GREEN_SECTORS = 2;
  localparam int BLUE_SECTORS  = 4;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic    grey;
    logic    neg;
    sector_e sector;
  } hsv_ctl_t;

endpackage

// ===== sv/rhc_pix_in_if.sv =====
interface rhc_pix_in_if #(
  parameter int CW = 12
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== sv/rhc_pix_out_if.sv =====
interface rhc_pix_out_if #(
  parameter int CW = 12,
  parameter int FB = 6
);
  logic          valid;
  logic          ready;
  logic [FB+8:0] hue;
  logic [CW-1:0] saturation;
  logic [CW-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== sv/rgb_to_hsv_converter_unit.sv =====
// channel | dir | transfer moves
// pix_i   | in  | red, green, blue (COMPONENT_BITS each)
// hsv_o   | out | hue (HUE_FRAC_BITS+9), saturation, brightness (COMPONENT_BITS)
//
// one pixel per cycle sustained while hsv_o is ready, through a front stage, the divider
// stages of the two restoring dividers (one quotient bit per stage) and a back stage
// each stage has its own valid bit and registers on ready, so bubbles close up
// and a stall at hsv_o backs up stage by stage without loss or repeats
// rst_ni clears only the valid bits; payload registers are not reset
module rgb_to_hsv_converter_unit #(
  parameter int COMPONENT_BITS = 12,
  parameter int HUE_FRAC_BITS  = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rhc_pix_in_if.sink   pix_i,
  rhc_pix_out_if.source hsv_o
);
  import rhc_pkg::*;

  localparam int CW  = COMPONENT_BITS;
  localparam int FB  = HUE_FRAC_BITS;
  localparam int SNW = 2 * CW;
  localparam int HNW = CW + FB + 6;
  localparam int HQW = FB + 6;
  localparam int NST = (CW > HQW) ? CW : HQW;

  logic           vld     [NST+1];
  logic           rdy     [NST+1];
  hsv_ctl_t       ctl     [NST+1];
  logic [CW-1:0]  mx      [NST+1];
  logic [CW-1:0]  dl      [NST+1];
  logic [SNW-1:0] sat_rem [NST+1];
  logic [CW-1:0]  sat_quo [NST+1];
  logic [HNW-1:0] hue_rem [NST+1];
  logic [HQW-1:0] hue_quo [NST+1];

  rhc_front #(
    .CW (CW),
    .FB (FB)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (pix_i.valid),
    .ready_o   (pix_i.ready),
    .red_i     (pix_i.red),
    .green_i   (pix_i.green),
    .blue_i    (pix_i.blue),
    .valid_o   (vld[0]),
    .ready_i   (rdy[0]),
    .ctl_o     (ctl[0]),
    .max_o     (mx[0]),
    .delta_o   (dl[0]),
    .sat_num_o (sat_rem[0]),
    .hue_num_o (hue_rem[0])
  );

  assign sat_quo[0] = '0;
  assign hue_quo[0] = '0;

  for (genvar k = 0; k < NST; k++) begin : g_div
    rhc_div_step #(
      .CW  (CW),
      .FB  (FB),
      .BIT (NST - 1 - k)
    ) u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[k]),
      .ready_o   (rdy[k]),
      .ctl_i     (ctl[k]),
      .max_i     (mx[k]),
      .delta_i   (dl[k]),
      .sat_rem_i (sat_rem[k]),
      .sat_quo_i (sat_quo[k]),
      .hue_rem_i (hue_rem[k]),
      .hue_quo_i (hue_quo[k]),
      .valid_o   (vld[k+1]),
      .ready_i   (rdy[k+1]),
      .ctl_o     (ctl[k+1]),
      .max_o     (mx[k+1]),
      .delta_o   (dl[k+1]),
      .sat_rem_o (sat_rem[k+1]),
      .sat_quo_o (sat_quo[k+1]),
      .hue_rem_o (hue_rem[k+1]),
      .hue_quo_o (hue_quo[k+1])
    );
  end

  rhc_back #(
    .CW (CW),
    .FB (FB)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld[NST]),
    .ready_o   (rdy[NST]),
    .ctl_i     (ctl[NST]),
    .max_i     (mx[NST]),
    .sat_quo_i (sat_quo[NST]),
    .hue_rem_i (hue_rem[NST]),
    .hue_quo_i (hue_quo[NST]),
    .valid_o   (hsv_o.valid),
    .ready_i   (hsv_o.ready),
    .hue_o     (hsv_o.hue),
    .sat_o     (hsv_o.saturation),
    .bright_o  (hsv_o.brightness)
  );

endmodule

// ===== sv/rhc_front.sv =====
module rhc_front #(
  parameter int CW = 12,
  parameter int FB = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [CW-1:0]       red_i,
  input  logic [CW-1:0]       green_i,
  input  logic [CW-1:0]       blue_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rhc_pkg::hsv_ctl_t   ctl_o,
  output logic [CW-1:0]       max_o,
  output logic [CW-1:0]       delta_o,
  output logic [2*CW-1:0]     sat_num_o,
  output logic [CW+FB+5:0]    hue_num_o
);
  import rhc_pkg::*;

  localparam int HNW = CW + FB + 6;
  localparam logic [HNW-1:0] SectorScale = HNW'(SECTOR_DEG) << FB;

  logic [CW-1:0]        mx;
  logic [CW-1:0]        mn;
  logic [CW-1:0]        delta;
  logic signed [CW:0]   dif;
  logic [CW-1:0]        ad;
  logic [CW:0]          dif_neg;
  sector_e              sec;

  logic                 valid_q;
  hsv_ctl_t             ctl_d, ctl_q;
  logic [CW-1:0]        max_q, delta_q;
  logic [2*CW-1:0]      sat_num_d, sat_num_q;
  logic [HNW-1:0]       hue_num_d, hue_num_q;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    if (red_i >= mx) begin
      sec = SECT_RED;
      dif = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= mx) begin
      sec = SECT_GREEN;
      dif = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sec = SECT_BLUE;
      dif = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    dif_neg = -dif;
    ad = dif[CW] ? dif_neg[CW-1:0] : dif[CW-1:0];
    ctl_d.grey   = (delta == '0);
    ctl_d.neg    = dif[CW];
    ctl_d.sector = sec;
    sat_num_d = {delta, {CW{1'b0}}} - {{CW{1'b0}}, delta};
    hue_num_d = HNW'(ad) * SectorScale;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q     <= ctl_d;
      max_q     <= mx;
      delta_q   <= delta;
      sat_num_q <= sat_num_d;
      hue_num_q <= hue_num_d;
    end
  end

  assign valid_o   = valid_q;
  assign ctl_o     = ctl_q;
  assign max_o     = max_q;
  assign delta_o   = delta_q;
  assign sat_num_o = sat_num_q;
  assign hue_num_o = hue_num_q;

endmodule

// ===== sv/rhc_div_step.sv =====
module rhc_div_step #(
  parameter int CW  = 12,
  parameter int FB  = 6,
  parameter int BIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rhc_pkg::hsv_ctl_t   ctl_i,
  input  logic [CW-1:0]       max_i,
  input  logic [CW-1:0]       delta_i,
  input  logic [2*CW-1:0]     sat_rem_i,
  input  logic [CW-1:0]       sat_quo_i,
  input  logic [CW+FB+5:0]    hue_rem_i,
  input  logic [FB+5:0]       hue_quo_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rhc_pkg::hsv_ctl_t   ctl_o,
  output logic [CW-1:0]       max_o,
  output logic [CW-1:0]       delta_o,
  output logic [2*CW-1:0]     sat_rem_o,
  output logic [CW-1:0]       sat_quo_o,
  output logic [CW+FB+5:0]    hue_rem_o,
  output logic [FB+5:0]       hue_quo_o
);
  import rhc_pkg::*;

  localparam int SNW = 2 * CW;
  localparam int HNW = CW + FB + 6;
  localparam int SQW = CW;
  localparam int HQW = FB + 6;

  logic [SNW-1:0] sat_rem_d, sat_rem_q;
  logic [SQW-1:0] sat_quo_d, sat_quo_q;
  logic [HNW-1:0] hue_rem_d, hue_rem_q;
  logic [HQW-1:0] hue_quo_d, hue_quo_q;
  logic           valid_q;
  hsv_ctl_t       ctl_q;
  logic [CW-1:0]  max_q, delta_q;

  if (BIT < SQW) begin : g_sat
    logic [SNW-1:0] dvs;
    logic           take;
    assign dvs       = SNW'(max_i) << BIT;
    assign take      = (sat_rem_i >= dvs);
    assign sat_rem_d = take ? (sat_rem_i - dvs) : sat_rem_i;
    assign sat_quo_d = sat_quo_i | (SQW'(take) << BIT);
  end else begin : g_sat_hold
    assign sat_rem_d = sat_rem_i;
    assign sat_quo_d = sat_quo_i;
  end

  if (BIT < HQW) begin : g_hue
    logic [HNW-1:0] dvs;
    logic           take;
    assign dvs       = HNW'(delta_i) << BIT;
    assign take      = (hue_rem_i >= dvs);
    assign hue_rem_d = take ? (hue_rem_i - dvs) : hue_rem_i;
    assign hue_quo_d = hue_quo_i | (HQW'(take) << BIT);
  end else begin : g_hue_hold
    assign hue_rem_d = hue_rem_i;
    assign hue_quo_d = hue_quo_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q     <= ctl_i;
      max_q     <= max_i;
      delta_q   <= delta_i;
      sat_rem_q <= sat_rem_d;
      sat_quo_q <= sat_quo_d;
      hue_rem_q <= hue_rem_d;
      hue_quo_q <= hue_quo_d;
    end
  end

  assign valid_o   = valid_q;
  assign ctl_o     = ctl_q;
  assign max_o     = max_q;
  assign delta_o   = delta_q;
  assign sat_rem_o = sat_rem_q;
  assign sat_quo_o = sat_quo_q;
  assign hue_rem_o = hue_rem_q;
  assign hue_quo_o = hue_quo_q;

endmodule

// ===== sv/rhc_back.sv =====
module rhc_back #(
  parameter int CW = 12,
  parameter int FB = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rhc_pkg::hsv_ctl_t   ctl_i,
  input  logic [CW-1:0]       max_i,
  input  logic [CW-1:0]       sat_quo_i,
  input  logic [CW+FB+5:0]    hue_rem_i,
  input  logic [FB+5:0]       hue_quo_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [FB+8:0]       hue_o,
  output logic [CW-1:0]       sat_o,
  output logic [CW-1:0]       bright_o
);
  import rhc_pkg::*;

  localparam int HW  = FB + 9;
  localparam int HQW = FB + 6;
  localparam logic signed [HW:0] SectorScale = (HW+1)'(SECTOR_DEG) <<< FB;
  localparam logic signed [HW:0] FullTurn    = (HW+1)'(TURN_DEG) <<< FB;
  localparam logic signed [HW:0] GreenOffset = (HW+1)'(GREEN_SECTORS) * SectorScale;
  localparam logic signed [HW:0] BlueOffset  = (HW+1)'(BLUE_SECTORS) * SectorScale;

  logic [HQW:0]        mag;
  logic signed [HW:0]  offset;
  logic signed [HW:0]  hue_s;
  logic signed [HW:0]  hue_w;
  logic [HW-1:0]       hue_d, hue_q;
  logic [CW-1:0]       sat_d, sat_q, bright_q;
  logic                valid_q;

  always_comb begin
    case (ctl_i.sector)
      SECT_RED:   offset = '0;
      SECT_GREEN: offset = GreenOffset;
      SECT_BLUE:  offset = BlueOffset;
      default:    offset = '0;
    endcase
    // negative difference rounds toward minus infinity
    mag = {1'b0, hue_quo_i} + (HQW+1)'(ctl_i.neg && (hue_rem_i != '0));
    if (ctl_i.neg) begin
      hue_s = offset - $signed({{(HW-HQW){1'b0}}, mag});
    end else begin
      hue_s = offset + $signed({{(HW-HQW){1'b0}}, mag});
    end
    hue_w = hue_s[HW] ? (hue_s + FullTurn) : hue_s;
    if (ctl_i.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hue_w[HW-1:0];
      sat_d = sat_quo_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= max_i;
    end
  end

  assign valid_o  = valid_q;
  assign hue_o    = hue_q;
  assign sat_o    = sat_q;
  assign bright_o = bright_q;

endmodule
